[src/grw_pkg.sv]
// ----------------------------------------------------------------------------
// grw_pkg
// Shared types, codes and sizes for the grid ray wall hit block.
// ----------------------------------------------------------------------------
package grw_pkg;

  localparam int MAP_COLS_MAX  = 64;
  localparam int MAP_ROWS_MAX  = 64;
  localparam int POS_FRAC_BITS = 8;

  localparam int COL_W   = $clog2(MAP_COLS_MAX);
  localparam int ROW_W   = $clog2(MAP_ROWS_MAX);
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int DEPTH   = MAP_COLS_MAX * MAP_ROWS_MAX;
  localparam int POS_W   = 14;
  localparam int DIR_W   = 16;
  localparam int LIM_W   = 7;
  localparam int DIST_W  = 32;
  // quotient k carries 22 + fraction extension; 37 bits cover the largest offset
  localparam int Q_W     = 37;
  localparam int QLO_W   = 19;
  localparam int ACC_W   = 54;
  localparam int KSHIFT  = 30 - POS_FRAC_BITS;

  // input operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;

  // cell kinds
  localparam logic [1:0] KIND_OPEN    = 2'd0;
  localparam logic [1:0] KIND_WALL    = 2'd1;
  localparam logic [1:0] KIND_SPECIAL = 2'd2;
  localparam logic [1:0] KIND_BAD     = 2'd3;

  // reported wall faces
  localparam logic [1:0] FACE_VERT    = 2'd0;
  localparam logic [1:0] FACE_HORZ    = 2'd1;
  localparam logic [1:0] FACE_SPECIAL = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AX_INIT,
    ST_DIV_FIRST,
    ST_DIV_STEP,
    ST_MUL,
    ST_LINE_CHK,
    ST_LINE_EVAL,
    ST_AX_DONE,
    ST_FINISH
  } state_t;

  typedef enum logic {
    DIV_FIRST,
    DIV_STEP
  } div_sel_t;

  typedef struct packed {
    logic     clr_wr;
    logic     cell_wr;
    logic     load_cast;
    logic     axis_init;
    logic     div_start;
    div_sel_t div_sel;
    logic     store_first;
    logic     store_step;
    logic     mul_run;
    logic     rd_issue;
    logic     hit_rec;
    logic     step;
    logic     axis_next;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic dir_zero;
    logic div_done;
    logic mul_done;
    logic line_more;
    logic wall;
    logic axis;
  } sts_t;

endpackage

[src/grw_divider.sv]
// ----------------------------------------------------------------------------
// grw_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grw_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [grw_pkg::Q_W-1:0]      dividend,
  input  logic [grw_pkg::DIR_W-1:0]    divisor,
  output logic                         done,
  output logic [grw_pkg::Q_W-1:0]      quot,
  output logic [grw_pkg::DIR_W-1:0]    rem
);

  localparam int CNT_W = $clog2(grw_pkg::Q_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [grw_pkg::Q_W-1:0]     quo_r;
  logic [grw_pkg::DIR_W-1:0]   rem_r;
  logic [grw_pkg::DIR_W-1:0]   dvs_r;
  logic [grw_pkg::DIR_W:0]     trial;
  logic                        fits;

  // trial subtract of the next dividend bit
  always_comb begin
    trial = {rem_r, quo_r[grw_pkg::Q_W-1]};
    fits  = trial >= {1'b0, dvs_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNT_W'(grw_pkg::Q_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(grw_pkg::Q_W - 1)) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[grw_pkg::Q_W-2:0], fits};
      rem_r <= fits ? grw_pkg::DIR_W'(trial - {1'b0, dvs_r})
                    : grw_pkg::DIR_W'(trial);
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

[src/grw_datapath.sv]
// ----------------------------------------------------------------------------
// grw_datapath
// Map memory, cast registers, incremental line walk and result register.
// ----------------------------------------------------------------------------
module grw_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  grw_pkg::cmd_t                     cmd,
  output grw_pkg::sts_t                     sts,
  input  logic                              cfg_valid,
  input  logic [1:0]                        cfg_index,
  input  logic [grw_pkg::LIM_W-1:0]         cfg_data,
  input  logic [grw_pkg::COL_W-1:0]         in_cell_x,
  input  logic [grw_pkg::ROW_W-1:0]         in_cell_y,
  input  logic [1:0]                        in_cell_kind,
  input  logic [grw_pkg::POS_W-1:0]         in_pos_x,
  input  logic [grw_pkg::POS_W-1:0]         in_pos_y,
  input  logic signed [grw_pkg::DIR_W-1:0]  in_dir_x,
  input  logic signed [grw_pkg::DIR_W-1:0]  in_dir_y,
  output logic [grw_pkg::DIST_W-1:0]        out_distance,
  output logic [1:0]                        out_wall_kind,
  output logic                              out_hit
);

  localparam int PF = grw_pkg::POS_FRAC_BITS;
  localparam int QW = grw_pkg::Q_W;
  localparam int AW = grw_pkg::ACC_W;
  localparam int DW = grw_pkg::DIR_W;
  localparam int LW = grw_pkg::LIM_W;
  localparam int NW = LW + PF;
  localparam int PRW = grw_pkg::QLO_W + 1 + DW;
  localparam int QLO_W_T = grw_pkg::QLO_W + 1;

  // config
  logic [LW-1:0] map_w_r, map_h_r;
  logic [LW-1:0] eff_w, eff_h;

  // memory
  logic [1:0]                   mem [grw_pkg::DEPTH];
  logic [grw_pkg::ADDR_W-1:0]   clr_cnt_r;
  logic [1:0]                   rd_kind_r;
  logic                         rd_ok_r;

  // cast
  logic [grw_pkg::POS_W-1:0]    pos_x_r, pos_y_r;
  logic signed [DW-1:0]         dir_x_r, dir_y_r;
  logic                         axis_r;

  // walk
  logic [LW-1:0]                line_r;
  logic [QW-1:0]                k_r, qs_r;
  logic [DW-1:0]                r_r, rs_r;
  logic signed [AW-1:0]         c_r, p_r;
  logic signed [PRW-1:0]        prod_r;
  logic [2:0]                   mstep_r;

  // hits
  logic                         hx_r, hy_r;
  logic [QW-1:0]                kx_r, ky_r;
  logic [1:0]                   tx_r, ty_r;

  // divider link
  logic                         div_done;
  logic [QW-1:0]                div_q;
  logic [DW-1:0]                div_r;
  logic [QW-1:0]                dividend;

  // axis selection
  logic [grw_pkg::POS_W-1:0]    pos_a, pos_b;
  logic signed [DW-1:0]         dir_a, dir_b;
  logic [LW-1:0]                lim_a, lim_b;
  logic                         dir_neg;
  logic [DW-1:0]                mag;
  logic [LW-1:0]                floor_a, line_init;
  logic [NW-1:0]                num0;
  logic [LW-1:0]                ca_w;
  logic [grw_pkg::COL_W-1:0]    ca;
  logic [23:0]                  c_hi;
  logic                         in_rng;
  logic [grw_pkg::COL_W-1:0]    cb;
  logic [grw_pkg::ADDR_W-1:0]   rd_addr;
  logic [QLO_W_T-1:0]           mul_a;
  logic signed [PRW-1:0]        prod;
  logic signed [AW-1:0]         prod_ext;
  logic signed [AW-1:0]         dir_b_ext;
  logic [DW:0]                  r_sum;
  logic                         carry;

  // effective map size
  always_comb begin
    eff_w = (map_w_r > LW'(grw_pkg::MAP_COLS_MAX)) ? LW'(grw_pkg::MAP_COLS_MAX) : map_w_r;
    eff_h = (map_h_r > LW'(grw_pkg::MAP_ROWS_MAX)) ? LW'(grw_pkg::MAP_ROWS_MAX) : map_h_r;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r <= LW'(64);
      map_h_r <= LW'(64);
    end else if (cfg_valid) begin
      case (cfg_index)
        grw_pkg::CFG_MAP_WIDTH:  map_w_r <= cfg_data;
        grw_pkg::CFG_MAP_HEIGHT: map_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // axis operand selection
  always_comb begin
    pos_a   = axis_r ? pos_y_r : pos_x_r;
    pos_b   = axis_r ? pos_x_r : pos_y_r;
    dir_a   = axis_r ? dir_y_r : dir_x_r;
    dir_b   = axis_r ? dir_x_r : dir_y_r;
    lim_a   = axis_r ? eff_h : eff_w;
    lim_b   = axis_r ? eff_w : eff_h;
    dir_neg = dir_a[DW-1];
    mag     = dir_neg ? DW'(~dir_a + 1'b1) : DW'(dir_a);
    floor_a = LW'(pos_a[grw_pkg::POS_W-1:PF]);
    if (dir_neg) begin
      line_init = (floor_a < lim_a) ? floor_a : lim_a;
      num0      = NW'({1'b0, pos_a} - {line_init, {PF{1'b0}}});
    end else begin
      line_init = floor_a + 1'b1;
      num0      = NW'({line_init, {PF{1'b0}}} - {1'b0, pos_a});
    end
    dividend = (cmd.div_sel == grw_pkg::DIV_FIRST) ?
               QW'({num0, {grw_pkg::KSHIFT{1'b0}}}) : QW'(1) << 30;
  end

  // divider
  grw_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (mag),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // cell address of the current line; a crossing in (-1, 0) lands on index 0
  always_comb begin
    ca_w   = dir_neg ? line_r - 1'b1 : line_r;
    ca     = ca_w[grw_pkg::COL_W-1:0];
    c_hi   = c_r[AW-1:30];
    if (c_r[AW-1]) begin
      in_rng = (&c_hi) && (c_r[29:0] != '0) && (lim_b != '0);
      cb     = '0;
    end else begin
      in_rng = c_hi < 24'(lim_b);
      cb     = c_r[30+grw_pkg::COL_W-1:30];
    end
    rd_addr = axis_r ? {ca, cb} : {cb, ca};
  end

  // multiplier operand and product
  always_comb begin
    case (mstep_r)
      3'd0:    mul_a = QLO_W_T'(k_r[grw_pkg::QLO_W-1:0]);
      3'd1:    mul_a = QLO_W_T'(k_r[QW-1:grw_pkg::QLO_W]);
      3'd2:    mul_a = QLO_W_T'(qs_r[grw_pkg::QLO_W-1:0]);
      3'd3:    mul_a = QLO_W_T'(qs_r[QW-1:grw_pkg::QLO_W]);
      default: mul_a = '0;
    endcase
    prod      = $signed({1'b0, mul_a}) * dir_b;
    prod_ext  = {{(AW-PRW){prod_r[PRW-1]}}, prod_r};
    dir_b_ext = {{(AW-DW){dir_b[DW-1]}}, dir_b};
    r_sum     = {1'b0, r_r} + {1'b0, rs_r};
    carry     = r_sum >= {1'b0, mag};
  end

  // map memory: clearing pass and cell writes
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt_r] <= grw_pkg::KIND_OPEN;
    end else if (cmd.cell_wr) begin
      mem[{in_cell_y, in_cell_x}] <= (in_cell_kind == grw_pkg::KIND_BAD) ?
                                     grw_pkg::KIND_OPEN : in_cell_kind;
    end
  end

  // map memory read
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_kind_r <= mem[rd_addr];
      rd_ok_r   <= in_rng;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      mstep_r   <= '0;
      axis_r    <= 1'b0;
      hx_r      <= 1'b0;
      hy_r      <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.mul_run) mstep_r <= (mstep_r == 3'd4) ? 3'd0 : mstep_r + 1'b1;
      if (cmd.load_cast) begin
        axis_r <= 1'b0;
        hx_r   <= 1'b0;
        hy_r   <= 1'b0;
      end
      if (cmd.axis_next) axis_r <= 1'b1;
      if (cmd.hit_rec) begin
        if (axis_r) hy_r <= 1'b1;
        else        hx_r <= 1'b1;
      end
    end
  end

  // cast and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load_cast) begin
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      dir_x_r <= in_dir_x;
      dir_y_r <= in_dir_y;
    end
    if (cmd.axis_init) line_r <= line_init;
    if (cmd.store_first) begin
      k_r <= div_q;
      r_r <= div_r;
    end
    if (cmd.store_step) begin
      qs_r <= div_q;
      rs_r <= div_r;
    end
    // crossing start and per-line increment, two partial products each
    if (cmd.mul_run) begin
      prod_r <= prod;
      case (mstep_r)
        3'd1:    c_r <= AW'({pos_b, {grw_pkg::KSHIFT{1'b0}}}) + prod_ext;
        3'd2:    c_r <= c_r + (prod_ext <<< grw_pkg::QLO_W);
        3'd3:    p_r <= prod_ext;
        3'd4:    p_r <= p_r + (prod_ext <<< grw_pkg::QLO_W);
        default: ;
      endcase
    end
    // advance one grid line
    if (cmd.step) begin
      line_r <= dir_neg ? line_r - 1'b1 : line_r + 1'b1;
      k_r    <= k_r + qs_r + QW'(carry);
      r_r    <= carry ? DW'(r_sum - {1'b0, mag}) : DW'(r_sum);
      c_r    <= c_r + p_r + (carry ? dir_b_ext : '0);
    end
    if (cmd.hit_rec) begin
      if (axis_r) begin
        ky_r <= k_r;
        ty_r <= rd_kind_r;
      end else begin
        kx_r <= k_r;
        tx_r <= rd_kind_r;
      end
    end
  end

  // result select and output register
  logic                 sel_y;
  logic [QW-1:0]        k_fin;
  logic [1:0]           face;

  always_comb begin
    sel_y = hy_r && (!hx_r || (ky_r <= kx_r));
    if (sel_y) begin
      k_fin = ky_r;
      face  = (ty_r == grw_pkg::KIND_SPECIAL) ? grw_pkg::FACE_SPECIAL : grw_pkg::FACE_HORZ;
    end else begin
      k_fin = kx_r;
      face  = (tx_r == grw_pkg::KIND_SPECIAL) ? grw_pkg::FACE_SPECIAL : grw_pkg::FACE_VERT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (!hx_r && !hy_r) begin
        out_distance  <= '1;
        out_wall_kind <= grw_pkg::FACE_VERT;
        out_hit       <= 1'b0;
      end else begin
        out_distance  <= (k_fin[QW-1:grw_pkg::DIST_W] != '0) ? '1 :
                         k_fin[grw_pkg::DIST_W-1:0];
        out_wall_kind <= face;
        out_hit       <= 1'b1;
      end
    end
  end

  // status
  always_comb begin
    sts.clear_last = clr_cnt_r == grw_pkg::ADDR_W'(grw_pkg::DEPTH - 1);
    sts.dir_zero   = dir_a == '0;
    sts.div_done   = div_done;
    sts.mul_done   = cmd.mul_run && (mstep_r == 3'd4);
    sts.line_more  = dir_neg ? (line_r != '0) : (line_r < lim_a);
    sts.wall       = rd_ok_r && ((rd_kind_r == grw_pkg::KIND_WALL) ||
                                 (rd_kind_r == grw_pkg::KIND_SPECIAL));
    sts.axis       = axis_r;
  end

endmodule

[src/grw_ctrl.sv]
// ----------------------------------------------------------------------------
// grw_ctrl
// Sequencer: clearing pass, item intake, per-axis walk and result hand-off.
// ----------------------------------------------------------------------------
module grw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_operation,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  grw_pkg::sts_t  sts,
  output grw_pkg::cmd_t  cmd
);

  grw_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            out_free;

  assign accept   = in_valid && (state_r == grw_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      grw_pkg::ST_CLEAR:     if (sts.clear_last) state_nxt = grw_pkg::ST_IDLE;
      grw_pkg::ST_IDLE:      if (accept && in_operation == grw_pkg::OP_CAST)
                               state_nxt = grw_pkg::ST_AX_INIT;
      grw_pkg::ST_AX_INIT:   state_nxt = sts.dir_zero ? grw_pkg::ST_AX_DONE
                                                      : grw_pkg::ST_DIV_FIRST;
      grw_pkg::ST_DIV_FIRST: if (sts.div_done) state_nxt = grw_pkg::ST_DIV_STEP;
      grw_pkg::ST_DIV_STEP:  if (sts.div_done) state_nxt = grw_pkg::ST_MUL;
      grw_pkg::ST_MUL:       if (sts.mul_done) state_nxt = grw_pkg::ST_LINE_CHK;
      grw_pkg::ST_LINE_CHK:  state_nxt = sts.line_more ? grw_pkg::ST_LINE_EVAL
                                                       : grw_pkg::ST_AX_DONE;
      grw_pkg::ST_LINE_EVAL: state_nxt = sts.wall ? grw_pkg::ST_AX_DONE
                                                  : grw_pkg::ST_LINE_CHK;
      grw_pkg::ST_AX_DONE:   state_nxt = sts.axis ? grw_pkg::ST_FINISH
                                                  : grw_pkg::ST_AX_INIT;
      grw_pkg::ST_FINISH:    if (out_free) state_nxt = grw_pkg::ST_IDLE;
      default:               state_nxt = grw_pkg::ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd         = '0;
    cmd.div_sel = grw_pkg::DIV_FIRST;
    case (state_r)
      grw_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
      grw_pkg::ST_IDLE: begin
        cmd.cell_wr   = accept && (in_operation == grw_pkg::OP_WRITE);
        cmd.load_cast = accept && (in_operation == grw_pkg::OP_CAST);
      end
      grw_pkg::ST_AX_INIT: begin
        cmd.axis_init = 1'b1;
        cmd.div_start = !sts.dir_zero;
      end
      grw_pkg::ST_DIV_FIRST: begin
        cmd.store_first = sts.div_done;
        cmd.div_start   = sts.div_done;
        cmd.div_sel     = grw_pkg::DIV_STEP;
      end
      grw_pkg::ST_DIV_STEP:  cmd.store_step = sts.div_done;
      grw_pkg::ST_MUL:       cmd.mul_run    = 1'b1;
      grw_pkg::ST_LINE_CHK:  cmd.rd_issue   = sts.line_more;
      grw_pkg::ST_LINE_EVAL: begin
        cmd.hit_rec = sts.wall;
        cmd.step    = !sts.wall;
      end
      grw_pkg::ST_AX_DONE:   cmd.axis_next  = !sts.axis;
      grw_pkg::ST_FINISH:    cmd.out_load   = out_free;
      default: ;
    endcase
  end

  // result beat holding
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load)              out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grw_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != grw_pkg::ST_IDLE;
  assign out_valid = out_valid_r;

endmodule

[src/grid_ray_wall_hit.sv]
// ----------------------------------------------------------------------------
// grid_ray_wall_hit
// Grid map store and ray cast to the nearest wall on vertical/horizontal lines.
// ----------------------------------------------------------------------------
// Cell write: stored in the map memory when accepted. Cast: per axis, two
// divides on the shared restoring divider plus five multiply steps, then a map
// read and a step for each grid line walked.
// One item at a time; a finished result waits in the output register.
// Reset: synchronous, active low; then a clearing pass over all 4096 map
// cells, during which no item is taken (configuration writes are).
// ----------------------------------------------------------------------------
module grid_ray_wall_hit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [grw_pkg::COL_W-1:0]         in_cell_x,
  input  logic [grw_pkg::ROW_W-1:0]         in_cell_y,
  input  logic [1:0]                        in_cell_kind,
  input  logic [grw_pkg::POS_W-1:0]         in_pos_x,
  input  logic [grw_pkg::POS_W-1:0]         in_pos_y,
  input  logic signed [grw_pkg::DIR_W-1:0]  in_dir_x,
  input  logic signed [grw_pkg::DIR_W-1:0]  in_dir_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [grw_pkg::DIST_W-1:0]        out_distance,
  output logic [1:0]                        out_wall_kind,
  output logic                              out_hit,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [grw_pkg::LIM_W-1:0]         cfg_data
);

  grw_pkg::cmd_t cmd;
  grw_pkg::sts_t sts;

  // configuration always taken
  assign cfg_ready = 1'b1;

  grw_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  grw_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .in_cell_kind  (in_cell_kind),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_dir_x      (in_dir_x),
    .in_dir_y      (in_dir_y),
    .out_distance  (out_distance),
    .out_wall_kind (out_wall_kind),
    .out_hit       (out_hit)
  );

endmodule

[test/tb_grid_ray_wall_hit.sv]
// ----------------------------------------------------------------------------
// tb_grid_ray_wall_hit
// Self-checking bench for the grid ray wall hit block: map writes and ray
// casts through a directed table, then random phases over several map sizes;
// every cast result is checked against a local wall-distance predictor.
// ----------------------------------------------------------------------------
module tb_grid_ray_wall_hit;

  typedef struct {
    logic [grw_pkg::DIST_W-1:0] distance;
    logic [1:0]                 face;
    logic                       hit;
  } wall_hit_t;

  typedef struct {
    logic        op;
    logic [5:0]  cx;
    logic [5:0]  cy;
    logic [1:0]  kind;
    logic [13:0] px;
    logic [13:0] py;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    bit          typed;
    wall_hit_t   want;
  } cast_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_operation;
  logic [grw_pkg::COL_W-1:0] in_cell_x;
  logic [grw_pkg::ROW_W-1:0] in_cell_y;
  logic [1:0] in_cell_kind;
  logic [grw_pkg::POS_W-1:0] in_pos_x, in_pos_y;
  logic signed [grw_pkg::DIR_W-1:0] in_dir_x, in_dir_y;
  logic out_valid, out_stall;
  logic [grw_pkg::DIST_W-1:0] out_distance;
  logic [1:0] out_wall_kind;
  logic out_hit;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [grw_pkg::LIM_W-1:0] cfg_data;

  grid_ray_wall_hit u_dut (.*);

  // model state
  logic [1:0] grid_cells [0:grw_pkg::MAP_ROWS_MAX-1][0:grw_pkg::MAP_COLS_MAX-1];
  int unsigned grid_w, grid_h;
  wall_hit_t pending_hits [$];
  wall_hit_t typed_hits [$];
  bit typed_flag [$];
  int errors, n_casts, n_writes, n_hits, n_checked;
  bit calm;

  localparam wall_hit_t NO_WALL = '{32'hFFFF_FFFF, grw_pkg::FACE_VERT, 1'b0};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // walk the grid lines of one axis; returns 1 on the first wall
  function automatic bit walk_axis(longint pos_a, longint dir_a, longint pos_b,
                                   longint dir_b, bit along_x,
                                   output longint k_o, output logic [1:0] kind_o);
    longint ew, eh, lim_a, lim_b, mag, den, fl, line, stop, stp;
    longint lp, num, k, c, cb, ca;
    logic [1:0] kd;
    ew = grid_w < grw_pkg::MAP_COLS_MAX ? grid_w : grw_pkg::MAP_COLS_MAX;
    eh = grid_h < grw_pkg::MAP_ROWS_MAX ? grid_h : grw_pkg::MAP_ROWS_MAX;
    lim_a = along_x ? ew : eh;
    lim_b = along_x ? eh : ew;
    k_o = 0;
    kind_o = grw_pkg::KIND_OPEN;
    if (dir_a == 0) return 1'b0;
    mag = dir_a < 0 ? -dir_a : dir_a;
    den = mag << grw_pkg::POS_FRAC_BITS;
    fl = pos_a >> grw_pkg::POS_FRAC_BITS;
    if (dir_a > 0) begin
      line = fl + 1; stop = lim_a; stp = 1;
    end else begin
      line = fl < lim_a ? fl : lim_a; stop = 0; stp = -1;
    end
    while (line != stop && !(stp > 0 && line > stop)) begin
      lp = line << grw_pkg::POS_FRAC_BITS;
      num = lp >= pos_a ? lp - pos_a : pos_a - lp;
      k = (num << 30) / den;
      c = (pos_b << grw_pkg::KSHIFT) + k * dir_b;
      ca = stp > 0 ? line : line - 1;
      if (c > -(longint'(1) << 30)) begin
        cb = c < 0 ? 0 : (c >> 30);
        if (cb < lim_b) begin
          kd = grw_pkg::KIND_OPEN;
          if (along_x && ca < ew && cb < eh) kd = grid_cells[cb][ca];
          if (!along_x && cb < ew && ca < eh) kd = grid_cells[ca][cb];
          if (kd == grw_pkg::KIND_WALL || kd == grw_pkg::KIND_SPECIAL) begin
            k_o = k;
            kind_o = kd;
            return 1'b1;
          end
        end
      end
      line += stp;
    end
    return 1'b0;
  endfunction

  // apply an accepted beat to the map or queue the expected wall hit
  function automatic void predict_beat(cast_row_t r);
    longint kx, ky, k;
    logic [1:0] tx, ty;
    bit hx, hy;
    wall_hit_t w;
    if (r.op == grw_pkg::OP_WRITE) begin
      grid_cells[r.cy][r.cx] = (r.kind == grw_pkg::KIND_BAD) ? grw_pkg::KIND_OPEN : r.kind;
      n_writes++;
      return;
    end
    hx = walk_axis(r.px, r.dx, r.py, r.dy, 1'b1, kx, tx);
    hy = walk_axis(r.py, r.dy, r.px, r.dx, 1'b0, ky, ty);
    if (!hx && !hy) begin
      w = NO_WALL;
    end else begin
      if (hy && (!hx || ky <= kx)) begin
        k = ky;
        w.face = (ty == grw_pkg::KIND_SPECIAL) ? grw_pkg::FACE_SPECIAL : grw_pkg::FACE_HORZ;
      end else begin
        k = kx;
        w.face = (tx == grw_pkg::KIND_SPECIAL) ? grw_pkg::FACE_SPECIAL : grw_pkg::FACE_VERT;
      end
      w.distance = (k > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : k[31:0];
      w.hit = 1'b1;
    end
    pending_hits.push_back(w);
    typed_hits.push_back(r.want);
    typed_flag.push_back(r.typed);
    n_casts++;
  endfunction

  // send one beat: random gap (none when calm), then hold until accepted
  task automatic send_beat(cast_row_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= r.op;
    in_cell_x    <= r.cx;
    in_cell_y    <= r.cy;
    in_cell_kind <= r.kind;
    in_pos_x     <= r.px;
    in_pos_y     <= r.py;
    in_dir_x     <= r.dx;
    in_dir_y     <= r.dy;
    do @(posedge clk); while (in_stall);
    predict_beat(r);
  endtask

  // write one register; the caller drops cfg_valid after the last write
  task automatic write_reg(logic [1:0] idx, logic [grw_pkg::LIM_W-1:0] val);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == grw_pkg::CFG_MAP_WIDTH) grid_w = val;
    else if (idx == grw_pkg::CFG_MAP_HEIGHT) grid_h = val;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // result receiver: random stall per beat (none when calm)
  initial begin
    int n;
    out_stall <= 1'b1;
    @(posedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  // result checker
  always @(posedge clk) begin
    wall_hit_t w, t;
    bit ty;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $error("result beat with nothing expected: distance=%h", out_distance);
        errors++;
      end else begin
        w = pending_hits.pop_front();
        t = typed_hits.pop_front();
        ty = typed_flag.pop_front();
        // directed rows with a hand value must agree with the predictor too
        if (ty && (t.distance !== w.distance || t.face !== w.face || t.hit !== w.hit)) begin
          $error("typed row disagrees: distance %h/%h", t.distance, w.distance);
          errors++;
        end
        if (out_distance !== w.distance) begin
          $error("distance: expected %h, got %h", w.distance, out_distance);
          errors++;
        end
        if (out_wall_kind !== w.face) begin
          $error("wall_kind: expected %0d, got %0d", w.face, out_wall_kind);
          errors++;
        end
        if (out_hit !== w.hit) begin
          $error("hit: expected %0d, got %0d", w.hit, out_hit);
          errors++;
        end
        if (w.hit) n_hits++;
        n_checked++;
      end
    end
  end

  function automatic cast_row_t mk(logic op, int cx, int cy, int kind, int px, int py,
                                   int dx, int dy, bit typed, wall_hit_t want);
    cast_row_t r;
    r.op = op; r.cx = cx; r.cy = cy; r.kind = kind;
    r.px = px; r.py = py; r.dx = dx; r.dy = dy;
    r.typed = typed; r.want = want;
    return r;
  endfunction

  // random beat: mostly in-map walls and casts from inside the map
  function automatic cast_row_t rand_beat();
    cast_row_t r;
    int ew, eh, sel;
    ew = grid_w < grw_pkg::MAP_COLS_MAX ? grid_w : grw_pkg::MAP_COLS_MAX;
    eh = grid_h < grw_pkg::MAP_ROWS_MAX ? grid_h : grw_pkg::MAP_ROWS_MAX;
    r = mk(grw_pkg::OP_CAST, $urandom_range(0, 63), $urandom_range(0, 63),
           $urandom_range(0, 3), $urandom_range(0, 16383), $urandom_range(0, 16383),
           $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b0, NO_WALL);
    r.op = ($urandom_range(0, 9) < 4) ? grw_pkg::OP_WRITE : grw_pkg::OP_CAST;
    if (r.op == grw_pkg::OP_WRITE) begin
      if (ew > 0 && eh > 0 && $urandom_range(0, 9) < 8) begin
        r.cx = $urandom_range(0, ew - 1);
        r.cy = $urandom_range(0, eh - 1);
      end
      if ($urandom_range(0, 9) < 6) r.kind = $urandom_range(1, 2);
    end else begin
      if (ew > 0 && eh > 0 && $urandom_range(0, 9) < 8) begin
        r.px = $urandom_range(0, ew * 256 - 1);
        r.py = $urandom_range(0, eh * 256 - 1);
      end
      sel = $urandom_range(0, 19);
      if (sel == 0) r.dx = 0;
      else if (sel == 1) r.dy = 0;
      else if (sel == 2) r.dx = $urandom_range(0, 1) ? 1 : -1;
      else if (sel == 3) r.dy = $urandom_range(0, 1) ? 3 : -3;
    end
    return r;
  endfunction

  localparam int N_ROWS = 19;

  initial begin
    cast_row_t rows [N_ROWS];
    int widths [5];
    int heights [5];
    rows[0]  = mk(grw_pkg::OP_CAST, 0, 0, 0, 'h580, 'h580, 16384, 0, 1, NO_WALL);
    rows[1]  = mk(grw_pkg::OP_CAST, 0, 0, 0, 'h580, 'h580, 0, 0, 1, NO_WALL);
    rows[2]  = mk(grw_pkg::OP_WRITE, 10, 5, grw_pkg::KIND_WALL, 0, 0, 0, 0, 0, NO_WALL);
    rows[3]  = mk(grw_pkg::OP_CAST, 0, 0, 0, 'h580, 'h580, 16384, 0, 1,
                  '{32'h0004_8000, grw_pkg::FACE_VERT, 1'b1});
    rows[4]  = mk(grw_pkg::OP_WRITE, 5, 10, grw_pkg::KIND_SPECIAL, 0, 0, 0, 0, 0, NO_WALL);
    rows[5]  = mk(grw_pkg::OP_CAST, 0, 0, 0, 'h580, 'h580, 0, 16384, 1,
                  '{32'h0004_8000, grw_pkg::FACE_SPECIAL, 1'b1});
    // far hit: tiny direction, distance saturates but hit stays
    rows[6]  = mk(grw_pkg::OP_CAST, 0, 0, 0, 'h580, 'h580, 1, 0, 1,
                  '{32'hFFFF_FFFF, grw_pkg::FACE_VERT, 1'b1});
    rows[7]  = mk(grw_pkg::OP_WRITE, 63, 63, grw_pkg::KIND_BAD, 0, 0, 0, 0, 0, NO_WALL);
    rows[8]  = mk(grw_pkg::OP_WRITE, 0, 0, grw_pkg::KIND_SPECIAL, 0, 0, 0, 0, 0, NO_WALL);
    rows[9]  = mk(grw_pkg::OP_CAST, 0, 0, 0, 'h3FFF, 'h3FFF, -32768, -32768, 0, NO_WALL);
    rows[10] = mk(grw_pkg::OP_CAST, 0, 0, 0, 0, 0, 32767, 32767, 0, NO_WALL);
    rows[11] = mk(grw_pkg::OP_WRITE, 63, 0, grw_pkg::KIND_WALL, 0, 0, 0, 0, 0, NO_WALL);
    rows[12] = mk(grw_pkg::OP_CAST, 0, 0, 0, 'h3FFF, 0, 32767, -1, 0, NO_WALL);
    rows[13] = mk(grw_pkg::OP_CAST, 0, 0, 0, 'h580, 'h580, -16384, 16384, 0, NO_WALL);
    rows[14] = mk(grw_pkg::OP_WRITE, 10, 5, grw_pkg::KIND_OPEN, 0, 0, 0, 0, 0, NO_WALL);
    rows[15] = mk(grw_pkg::OP_WRITE, 5, 10, grw_pkg::KIND_OPEN, 0, 0, 0, 0, 0, NO_WALL);
    rows[16] = mk(grw_pkg::OP_CAST, 0, 0, 0, 'h580, 'h580, 16384, 0, 1, NO_WALL);
    rows[17] = mk(grw_pkg::OP_WRITE, 6, 6, grw_pkg::KIND_WALL, 0, 0, 0, 0, 0, NO_WALL);
    // corner crossing: equal k on both axes, horizontal line wins
    rows[18] = mk(grw_pkg::OP_CAST, 0, 0, 0, 'h580, 'h580, 16384, 16384, 1,
                  '{32'h0000_8000, grw_pkg::FACE_HORZ, 1'b1});

    widths  = '{64, 1, 127, 0, 23};
    heights = '{64, 127, 1, 64, 9};

    for (int y = 0; y < grw_pkg::MAP_ROWS_MAX; y++)
      for (int x = 0; x < grw_pkg::MAP_COLS_MAX; x++) grid_cells[y][x] = grw_pkg::KIND_OPEN;
    grid_w = 64;
    grid_h = 64;
    errors = 0; n_casts = 0; n_writes = 0; n_hits = 0; n_checked = 0;
    calm = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0; in_operation <= grw_pkg::OP_WRITE;
    in_cell_x <= '0; in_cell_y <= '0; in_cell_kind <= grw_pkg::KIND_OPEN;
    in_pos_x <= '0; in_pos_y <= '0; in_dir_x <= '0; in_dir_y <= '0;
    cfg_valid <= 1'b0; cfg_index <= grw_pkg::CFG_MAP_WIDTH; cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table at reset sizes
    foreach (rows[i]) send_beat(rows[i]);

    // random phases, each with its own map size
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(grw_pkg::CFG_MAP_WIDTH, widths[p]);
      write_reg(grw_pkg::CFG_MAP_HEIGHT, heights[p]);
      write_reg(2'd2 + p[0], $urandom_range(0, 127));
      cfg_valid <= 1'b0;
      calm = (p == 2);
      for (int i = 0; i < 250; i++) send_beat(rand_beat());
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("covered %0d map writes and %0d casts (%0d hits) over 5 map sizes",
             n_writes, n_casts, n_hits);
    $display("%0d results checked, %0d mismatches", n_checked, errors);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
